[rtl/lz_run_decompressor_unit_defines.svh]
// ----------------------------------------------------------------------------
// LZ run decompressor assertion macros
// Shared concurrent assertion forms used by the decompressor RTL.
// ----------------------------------------------------------------------------
`ifndef LZ_RUN_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ_RUN_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LZRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define LZRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/lzrd_pkg.sv]
// ----------------------------------------------------------------------------
// LZ run decompressor package
// Types, command codes and constants shared by the decompressor RTL.
// ----------------------------------------------------------------------------
package lzrd_pkg;

    localparam int HISTORY_DEPTH    = 65536;
    localparam int BYTES_PER_RESULT = 16;

    localparam logic [7:0] END_HEADER = 8'hFF;
    localparam logic [4:0] LEN_MASK   = 5'h1F;

    localparam logic [2:0] CMD_LITERAL = 3'd0;
    localparam logic [2:0] CMD_FILL    = 3'd1;
    localparam logic [2:0] CMD_ALT     = 3'd2;
    localparam logic [2:0] CMD_INC     = 3'd3;
    localparam logic [2:0] CMD_COPY    = 3'd4;
    localparam logic [2:0] CMD_EXT     = 3'd7;

    typedef enum logic [3:0] {
        S_HEADER,
        S_EXT,
        S_LITERAL,
        S_OP1,
        S_OP2,
        S_GEN,
        S_COPY_RD,
        S_COPY_WR,
        S_EMIT
    } t_state;

endpackage

[rtl/lzrd_ram.sv]
// ----------------------------------------------------------------------------
// LZ run decompressor RAM
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module lzrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lz_run_decompressor_unit.sv]
// ----------------------------------------------------------------------------
// LZ run decompressor
// Expands an LC_LZ2 style byte stream into packed 16-byte output items.
// ----------------------------------------------------------------------------
// Header, length and operand bytes are taken while the output register is free;
// a literal byte's one-byte item is valid on the cycle after the byte is taken.
// Fill, alternating and incrementing runs produce one byte per cycle except while
// an item of up to 16 bytes is emitted from S_EMIT, which waits for the output; a
// copy run reads each byte from history RAM, then writes it. Synchronous,
// active-low reset clears control state only; the history RAM needs no clearing.
`include "lz_run_decompressor_unit_defines.svh"

module lz_run_decompressor_unit #(
    parameter int HISTORY_DEPTH = lzrd_pkg::HISTORY_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // comp_byte[7:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // data_lo[63:0], data_hi[127:64], byte_count[132:128], total_size[149:133]
    output logic [151:0] m_axis_tdata,
    output logic         m_axis_tlast,   // last_of_run
    output logic [1:0]   m_axis_tuser    // stream_done[0], bad_stream[1]
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int BPR = lzrd_pkg::BYTES_PER_RESULT;
    localparam logic [17:0] DepthW = 18'(HISTORY_DEPTH);

    lzrd_pkg::t_state r_state, n_state;

    logic [2:0]       r_cmd, n_cmd;
    logic [10:0]      r_len, n_len;
    logic [7:0]       r_op1, n_op1;
    logic [7:0]       r_op2, n_op2;
    logic [16:0]      r_wpos, n_wpos;
    logic [10:0]      r_idx, n_idx;
    logic [BPR*8-1:0] r_acc, n_acc;
    logic [4:0]       r_slot, n_slot;
    logic             r_last_blk, n_last_blk;

    logic             r_ovalid, n_ovalid;
    logic [63:0]      r_lo, n_lo;
    logic [63:0]      r_hi, n_hi;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_done, n_done;
    logic             r_bad, n_bad;
    logic [16:0]      r_total, n_total;

    logic             in_acc;
    logic             out_free;
    logic             accepting;
    logic [7:0]       b;
    logic             hdr_end, hdr_ext, hdr_bad;
    logic [2:0]       hdr_cmd;
    logic [10:0]      run_len;
    logic             run_ovf;
    logic [17:0]      run_end;
    logic [15:0]      offset;
    logic             off_bad;
    logic             produce;
    logic [7:0]       gen_byte;
    logic [10:0]      idx_inc;
    logic             run_last;
    logic             slot_full;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [16:0]      src_pos;
    logic [7:0]       ram_rdata;

    assign b         = s_axis_tdata;
    assign out_free  = !r_ovalid || m_axis_tready;
    assign accepting = (r_state == lzrd_pkg::S_HEADER) || (r_state == lzrd_pkg::S_EXT)
                    || (r_state == lzrd_pkg::S_LITERAL) || (r_state == lzrd_pkg::S_OP1)
                    || (r_state == lzrd_pkg::S_OP2);
    assign s_axis_tready = accepting && out_free;
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    // Header decode. An extended header carries its command in bits 4:2.
    assign hdr_end = (b == lzrd_pkg::END_HEADER);
    assign hdr_ext = (b[7:5] == lzrd_pkg::CMD_EXT);
    assign hdr_cmd = hdr_ext ? b[4:2] : b[7:5];
    assign hdr_bad = (hdr_cmd > lzrd_pkg::CMD_COPY);

    // Run length once known, and the overflow check against the history size.
    assign run_len = (r_state == lzrd_pkg::S_EXT) ? (r_len + 11'(b) + 11'd1)
                                                  : (11'(b[4:0] & lzrd_pkg::LEN_MASK) + 11'd1);
    assign run_end = {1'b0, r_wpos} + 18'(run_len);
    assign run_ovf = (run_end > DepthW);

    assign offset  = {b, r_op1};
    assign off_bad = (17'(offset) >= r_wpos);

    assign produce   = (r_state == lzrd_pkg::S_GEN) || (r_state == lzrd_pkg::S_COPY_WR);
    assign idx_inc   = r_idx + 11'd1;
    assign run_last  = (idx_inc == r_len);
    assign slot_full = (r_slot == 5'(BPR - 1));
    assign src_pos   = 17'({r_op2, r_op1}) + 17'(r_idx);

    always_comb begin
        case (r_cmd)
            lzrd_pkg::CMD_FILL: gen_byte = r_op1;
            lzrd_pkg::CMD_ALT:  gen_byte = r_idx[0] ? r_op2 : r_op1;
            lzrd_pkg::CMD_INC:  gen_byte = r_op1 + r_idx[7:0];
            default:            gen_byte = ram_rdata;
        endcase
    end

    assign ram_we    = produce || (in_acc && (r_state == lzrd_pkg::S_LITERAL));
    assign ram_waddr = r_wpos[AW-1:0];
    assign ram_wdata = produce ? gen_byte : b;

    lzrd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (src_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzrd_pkg::S_HEADER: begin
                if (in_acc && !hdr_end && !hdr_bad) begin
                    if (hdr_ext) begin
                        n_state = lzrd_pkg::S_EXT;
                    end else if (!run_ovf) begin
                        n_state = (hdr_cmd == lzrd_pkg::CMD_LITERAL) ? lzrd_pkg::S_LITERAL
                                                                      : lzrd_pkg::S_OP1;
                    end
                end
            end
            lzrd_pkg::S_EXT: begin
                if (in_acc) begin
                    if (run_ovf) begin
                        n_state = lzrd_pkg::S_HEADER;
                    end else begin
                        n_state = (r_cmd == lzrd_pkg::CMD_LITERAL) ? lzrd_pkg::S_LITERAL
                                                                    : lzrd_pkg::S_OP1;
                    end
                end
            end
            lzrd_pkg::S_LITERAL: begin
                if (in_acc && (r_len == 11'd1)) begin
                    n_state = lzrd_pkg::S_HEADER;
                end
            end
            lzrd_pkg::S_OP1: begin
                if (in_acc) begin
                    case (r_cmd)
                        lzrd_pkg::CMD_FILL, lzrd_pkg::CMD_INC: n_state = lzrd_pkg::S_GEN;
                        lzrd_pkg::CMD_ALT, lzrd_pkg::CMD_COPY: n_state = lzrd_pkg::S_OP2;
                        default:                               n_state = lzrd_pkg::S_HEADER;
                    endcase
                end
            end
            lzrd_pkg::S_OP2: begin
                if (in_acc) begin
                    if (r_cmd == lzrd_pkg::CMD_ALT) begin
                        n_state = lzrd_pkg::S_GEN;
                    end else if (r_cmd == lzrd_pkg::CMD_COPY && !off_bad) begin
                        n_state = lzrd_pkg::S_COPY_RD;
                    end else begin
                        n_state = lzrd_pkg::S_HEADER;
                    end
                end
            end
            lzrd_pkg::S_COPY_RD: n_state = lzrd_pkg::S_COPY_WR;
            lzrd_pkg::S_GEN, lzrd_pkg::S_COPY_WR: begin
                if (slot_full || run_last) begin
                    n_state = lzrd_pkg::S_EMIT;
                end else begin
                    n_state = (r_state == lzrd_pkg::S_GEN) ? lzrd_pkg::S_GEN
                                                           : lzrd_pkg::S_COPY_RD;
                end
            end
            lzrd_pkg::S_EMIT: begin
                if (out_free) begin
                    if (r_last_blk) begin
                        n_state = lzrd_pkg::S_HEADER;
                    end else begin
                        n_state = (r_cmd == lzrd_pkg::CMD_COPY) ? lzrd_pkg::S_COPY_RD
                                                                : lzrd_pkg::S_GEN;
                    end
                end
            end
            default: n_state = lzrd_pkg::S_HEADER;
        endcase
    end

    // Datapath and output item register.
    always_comb begin
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_op1      = r_op1;
        n_op2      = r_op2;
        n_wpos     = r_wpos;
        n_idx      = r_idx;
        n_acc      = r_acc;
        n_slot     = r_slot;
        n_last_blk = r_last_blk;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_done     = r_done;
        n_bad      = r_bad;
        n_total    = r_total;

        case (r_state)
            lzrd_pkg::S_HEADER: begin
                if (in_acc) begin
                    n_lo = '0;
                    n_hi = '0;
                    n_cnt = '0;
                    n_last = 1'b1;
                    n_done = 1'b0;
                    n_bad = 1'b0;
                    n_total = '0;
                    if (hdr_end) begin
                        n_ovalid = 1'b1;
                        n_done = 1'b1;
                        n_total = r_wpos;
                        n_wpos = '0;
                        n_len = '0;
                    end else begin
                        n_cmd = hdr_cmd;
                        if (hdr_bad || (!hdr_ext && run_ovf)) begin
                            n_ovalid = 1'b1;
                            n_bad = 1'b1;
                            n_wpos = '0;
                            n_len = '0;
                        end else if (hdr_ext) begin
                            n_len = {b[1:0], 8'd0} + 11'd0;
                        end else begin
                            n_len = run_len;
                        end
                    end
                end
            end
            lzrd_pkg::S_EXT: begin
                if (in_acc) begin
                    if (run_ovf) begin
                        n_ovalid = 1'b1;
                        n_lo = '0;
                        n_hi = '0;
                        n_cnt = '0;
                        n_last = 1'b1;
                        n_done = 1'b0;
                        n_bad = 1'b1;
                        n_total = '0;
                        n_wpos = '0;
                        n_len = '0;
                    end else begin
                        n_len = run_len;
                    end
                end
            end
            lzrd_pkg::S_LITERAL: begin
                if (in_acc) begin
                    n_ovalid = 1'b1;
                    n_lo = 64'(b);
                    n_hi = '0;
                    n_cnt = 5'd1;
                    n_last = 1'b1;
                    n_done = 1'b0;
                    n_bad = 1'b0;
                    n_total = '0;
                    n_wpos = r_wpos + 17'd1;
                    n_len = r_len - 11'd1;
                end
            end
            lzrd_pkg::S_OP1: begin
                if (in_acc) begin
                    n_op1 = b;
                    n_idx = '0;
                    n_slot = '0;
                    n_acc = '0;
                    if (r_cmd > lzrd_pkg::CMD_COPY || r_cmd == lzrd_pkg::CMD_LITERAL) begin
                        n_ovalid = 1'b1;
                        n_lo = '0;
                        n_hi = '0;
                        n_cnt = '0;
                        n_last = 1'b1;
                        n_done = 1'b0;
                        n_bad = 1'b1;
                        n_total = '0;
                        n_wpos = '0;
                        n_len = '0;
                    end
                end
            end
            lzrd_pkg::S_OP2: begin
                if (in_acc) begin
                    n_op2 = b;
                    if (!(r_cmd == lzrd_pkg::CMD_ALT)
                        && !(r_cmd == lzrd_pkg::CMD_COPY && !off_bad)) begin
                        n_ovalid = 1'b1;
                        n_lo = '0;
                        n_hi = '0;
                        n_cnt = '0;
                        n_last = 1'b1;
                        n_done = 1'b0;
                        n_bad = 1'b1;
                        n_total = '0;
                        n_wpos = '0;
                        n_len = '0;
                    end
                end
            end
            lzrd_pkg::S_GEN, lzrd_pkg::S_COPY_WR: begin
                for (int k = 0; k < BPR; k++) begin
                    if (r_slot[3:0] == 4'(k)) begin
                        n_acc[k*8 +: 8] = gen_byte;
                    end
                end
                n_slot = r_slot + 5'd1;
                n_idx = idx_inc;
                n_wpos = r_wpos + 17'd1;
                n_last_blk = run_last;
            end
            lzrd_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_lo = r_acc[63:0];
                    n_hi = r_acc[127:64];
                    n_cnt = r_slot;
                    n_last = r_last_blk;
                    n_done = 1'b0;
                    n_bad = 1'b0;
                    n_total = '0;
                    n_acc = '0;
                    n_slot = '0;
                    if (r_last_blk) begin
                        n_len = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lzrd_pkg::S_HEADER;
            r_cmd      <= '0;
            r_len      <= '0;
            r_op1      <= '0;
            r_op2      <= '0;
            r_wpos     <= '0;
            r_idx      <= '0;
            r_slot     <= '0;
            r_last_blk <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= n_cmd;
            r_len      <= n_len;
            r_op1      <= n_op1;
            r_op2      <= n_op2;
            r_wpos     <= n_wpos;
            r_idx      <= n_idx;
            r_slot     <= n_slot;
            r_last_blk <= n_last_blk;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_done  <= n_done;
        r_bad   <= n_bad;
        r_total <= n_total;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_total, r_cnt, r_hi, r_lo};
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = {r_bad, r_done};

    `LZRD_ASSERT_NOW(a_err_empty, i_clk, i_rst_n, r_ovalid && r_bad, (r_cnt == 5'd0) && r_last)
    `LZRD_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, r_ovalid, r_cnt <= 5'(BPR))
    `LZRD_ASSERT_NOW(a_wpos_range, i_clk, i_rst_n, 1'b1, {1'b0, r_wpos} <= DepthW)
    `LZRD_ASSERT_NEXT(a_err_restart, i_clk, i_rst_n, in_acc && n_bad && n_ovalid,
        (r_state == lzrd_pkg::S_HEADER) && (r_wpos == 17'd0))

endmodule

[tb/lz_run_decompressor_unit_checker.sv]
// ----------------------------------------------------------------------------
// LZ run decompressor checker
// Watches both streams, predicts the output items of every accepted
// compressed byte and compares them field by field, oldest first.
// ----------------------------------------------------------------------------
module lz_run_decompressor_unit_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [7:0]   i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [151:0] i_out_data,
    input  logic         i_out_last,
    input  logic [1:0]   i_out_user,
    output int           o_fail_count,
    output int           o_pending
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_EXT    = 3'd1;
    localparam logic [2:0] PH_LIT    = 3'd2;
    localparam logic [2:0] PH_OP1    = 3'd3;
    localparam logic [2:0] PH_OP2    = 3'd4;

    typedef struct packed {
        logic [151:0] data;
        logic         last;
        logic [1:0]   user;
    } t_out_item;

    t_out_item   expected_items[$];
    logic [2:0]  dec_phase;
    logic [2:0]  dec_cmd;
    int unsigned dec_len;
    logic [7:0]  dec_op_a;
    logic [7:0]  dec_op_b;
    int unsigned dec_wpos;
    logic [7:0]  dec_history[lzrd_pkg::HISTORY_DEPTH];

    assign o_pending = expected_items.size();

    function automatic t_out_item make_item(logic [127:0] bytes, logic [4:0] cnt,
                                            logic last, logic done, logic bad,
                                            logic [16:0] total);
        t_out_item it;
        it.data = {2'b00, total, cnt, bytes};
        it.last = last;
        it.user = {bad, done};
        return it;
    endfunction

    task automatic restart_on_error();
        dec_phase = PH_HEADER;
        dec_wpos  = 0;
        dec_len   = 0;
        expected_items.push_back(make_item('0, 5'd0, 1'b1, 1'b0, 1'b1, 17'd0));
    endtask

    task automatic check_run_fits();
        if (dec_wpos + dec_len > lzrd_pkg::HISTORY_DEPTH)
            restart_on_error();
        else
            dec_phase = (dec_cmd == lzrd_pkg::CMD_LITERAL) ? PH_LIT : PH_OP1;
    endtask

    // Writes the whole run into history, then packs it 16 bytes per item.
    task automatic expand_run();
        int unsigned  start;
        int unsigned  pos;
        int unsigned  offset;
        logic [7:0]   v;
        logic [127:0] bytes;
        int unsigned  cnt;
        start  = dec_wpos;
        offset = {dec_op_b, dec_op_a};
        for (int unsigned i = 0; i < dec_len; i++) begin
            case (dec_cmd)
                lzrd_pkg::CMD_FILL: v = dec_op_a;
                lzrd_pkg::CMD_ALT:  v = i[0] ? dec_op_b : dec_op_a;
                lzrd_pkg::CMD_INC:  v = dec_op_a + i[7:0];
                default:            v = dec_history[offset + i];
            endcase
            dec_history[start + i] = v;
        end
        pos = 0;
        while (pos < dec_len) begin
            cnt = (dec_len - pos > 16) ? 16 : dec_len - pos;
            bytes = '0;
            for (int unsigned i = 0; i < cnt; i++)
                bytes[8*i +: 8] = dec_history[start + pos + i];
            pos += cnt;
            expected_items.push_back(make_item(bytes, cnt[4:0], pos >= dec_len,
                                               1'b0, 1'b0, 17'd0));
        end
        dec_wpos  = start + dec_len;
        dec_phase = PH_HEADER;
        dec_len   = 0;
    endtask

    task automatic predict_byte(logic [7:0] b);
        case (dec_phase)
            PH_HEADER: begin
                if (b == lzrd_pkg::END_HEADER) begin
                    expected_items.push_back(make_item('0, 5'd0, 1'b1, 1'b1, 1'b0,
                                                       dec_wpos[16:0]));
                    dec_wpos = 0;
                    dec_len  = 0;
                end else if (b[7:5] == lzrd_pkg::CMD_EXT) begin
                    dec_cmd = b[4:2];
                    if (dec_cmd > lzrd_pkg::CMD_COPY)
                        restart_on_error();
                    else begin
                        dec_len   = b[1:0] << 8;
                        dec_phase = PH_EXT;
                    end
                end else begin
                    dec_cmd = b[7:5];
                    if (dec_cmd > lzrd_pkg::CMD_COPY)
                        restart_on_error();
                    else begin
                        dec_len = (b & lzrd_pkg::LEN_MASK) + 1;
                        check_run_fits();
                    end
                end
            end
            PH_EXT: begin
                dec_len = dec_len + b + 1;
                check_run_fits();
            end
            PH_LIT: begin
                dec_history[dec_wpos] = b;
                dec_wpos++;
                if (dec_len > 0)
                    dec_len--;
                if (dec_len == 0)
                    dec_phase = PH_HEADER;
                expected_items.push_back(make_item({120'd0, b}, 5'd1, 1'b1, 1'b0,
                                                   1'b0, 17'd0));
            end
            PH_OP1: begin
                dec_op_a = b;
                if (dec_cmd == lzrd_pkg::CMD_FILL || dec_cmd == lzrd_pkg::CMD_INC)
                    expand_run();
                else
                    dec_phase = PH_OP2;
            end
            default: begin
                dec_op_b = b;
                if (dec_cmd == lzrd_pkg::CMD_COPY && {dec_op_b, dec_op_a} >= dec_wpos)
                    restart_on_error();
                else
                    expand_run();
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            dec_phase <= PH_HEADER;
            dec_cmd   <= '0;
            dec_len   <= 0;
            dec_op_a  <= '0;
            dec_op_b  <= '0;
            dec_wpos  <= 0;
            o_fail_count <= 0;
            expected_items.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                got.data = i_out_data;
                got.last = i_out_last;
                got.user = i_out_user;
                if (expected_items.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual data=%h last=%b user=%b",
                             $time, got.data, got.last, got.user);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_items.pop_front();
                    if (got.data[63:0] !== want.data[63:0] ||
                        got.data[127:64] !== want.data[127:64] ||
                        got.data[132:128] !== want.data[132:128] ||
                        got.data[149:133] !== want.data[149:133] ||
                        got.last !== want.last || got.user !== want.user) begin
                        $display("%0t: mismatch, expected data=%h last=%b user=%b",
                                 $time, want.data, want.last, want.user);
                        $display("%0t:           actual   data=%h last=%b user=%b",
                                 $time, got.data, got.last, got.user);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/lz_run_decompressor_unit_test.sv]
// ----------------------------------------------------------------------------
// LZ run decompressor testbench
// Feeds directed and random compressed streams with bursty input and a
// stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module lz_run_decompressor_unit_test;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;     // comp_byte[7:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // data_lo[63:0], data_hi[127:64], byte_count[132:128], total_size[149:133]
    logic [151:0] m_axis_tdata;
    logic         m_axis_tlast;     // last_of_run
    logic [1:0]   m_axis_tuser;     // stream_done[0], bad_stream[1]
    int           fail_count;
    int           pending;
    int           cycle_count;
    logic         long_hold;
    logic [7:0]   stream_bytes[$];
    int unsigned  produced;         // bytes written in the current stream

    lz_run_decompressor_unit uut (.*);

    lz_run_decompressor_unit_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: a slowly changing stall pattern, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || long_hold)
            m_axis_tready <= 1'b0;
        else if (cycle_count[9])
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        long_hold = 1'b0;
        @(posedge i_clk);
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        long_hold = 1'b1;
        repeat (3000) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Header with a length of n (1..1024), short form when it fits.
    task automatic add_header(logic [2:0] cmd, int n);
        if (n <= 32)
            stream_bytes.push_back({cmd, 5'(n - 1)});
        else begin
            stream_bytes.push_back({lzrd_pkg::CMD_EXT, cmd, 2'((n - 1) >> 8)});
            stream_bytes.push_back(8'(n - 1));
        end
    endtask

    // One well-formed command with random content.
    task automatic add_command(int n);
        logic [2:0]  cmd;
        int unsigned off;
        cmd = 3'($urandom_range(0, 4));
        if (cmd == lzrd_pkg::CMD_COPY && produced == 0)
            cmd = lzrd_pkg::CMD_FILL;
        if (cmd == lzrd_pkg::CMD_LITERAL && n > 40)
            n = $urandom_range(1, 40);
        add_header(cmd, n);
        case (cmd)
            lzrd_pkg::CMD_LITERAL:
                for (int i = 0; i < n; i++)
                    stream_bytes.push_back(8'($urandom));
            lzrd_pkg::CMD_FILL, lzrd_pkg::CMD_INC: stream_bytes.push_back(8'($urandom));
            lzrd_pkg::CMD_ALT: begin
                stream_bytes.push_back(8'($urandom));
                stream_bytes.push_back(8'($urandom));
            end
            default: begin
                off = $urandom_range(0, produced - 1);
                stream_bytes.push_back(off[7:0]);
                stream_bytes.push_back(off[15:8]);
            end
        endcase
        produced += n;
    endtask

    task automatic send_all();
        while (stream_bytes.size() > 0) begin
            int burst;
            burst = $urandom_range(1, 12);
            while (burst > 0 && stream_bytes.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stream_bytes.pop_front();
                @(posedge i_clk);
                while (!s_axis_tready)
                    @(posedge i_clk);
                burst--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cycle_count   = 0;
        produced      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each command, extremes, special cases.
        stream_bytes = {8'hFF,                      // end of an empty stream
                        8'h01, 8'h00, 8'hFF,        // literal run of two bytes
                        8'h3F, 8'hA5,               // fill, 32 bytes
                        8'h41, 8'h12, 8'h34,        // alternating, 2 bytes
                        8'h7F, 8'hF0,               // incrementing, wraps
                        8'h83, 8'h43, 8'h00,        // overlapping copy
                        8'hE7, 8'hFF, 8'h55,        // extended fill, 1024 bytes
                        8'h81, 8'hFF, 8'hFF,        // copy offset past end
                        8'hA0,                      // invalid command 5
                        8'hF4,                      // invalid extended command
                        8'hE0, 8'h00, 8'h00,        // extended literal, 1 byte
                        8'hFF};
        send_all();

        // Overflow: fill history to the top, then one more byte.
        produced = 0;
        for (int c = 0; c < 64; c++) begin
            add_header(lzrd_pkg::CMD_FILL, 1024);
            stream_bytes.push_back(8'(c));
        end
        stream_bytes.push_back({lzrd_pkg::CMD_FILL, 5'd0});
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(lzrd_pkg::END_HEADER);
        send_all();

        // Random streams; mostly well formed, some noise.
        for (int s = 0; s < 3; s++) begin
            produced = 0;
            for (int c = 0; c < 5; c++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 1024)
                                                : $urandom_range(1, 32);
                add_command(n);
            end
            if ($urandom_range(0, 3) == 0)
                stream_bytes.push_back(8'($urandom));
            stream_bytes.push_back(lzrd_pkg::END_HEADER);
            send_all();
        end

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/lzrd_pkg.sv
rtl/lzrd_ram.sv
rtl/lz_run_decompressor_unit.sv
tb/lz_run_decompressor_unit_checker.sv
tb/lz_run_decompressor_unit_test.sv
